@@ src/mm3_pkg.sv @@
// Package for the 3x3 integer matrix multiplier.
// Holds sizes, the operand tag passed to the multiply-accumulate unit and the
// cell address helper. No dependencies.
`default_nettype none

package mm3_pkg;

  // Matrix size and derived widths.
  localparam int unsigned DIM         = 3;
  localparam int unsigned CELLS       = DIM * DIM;
  localparam int unsigned IDX_W       = (DIM > 2) ? $clog2(DIM) : 1;
  localparam int unsigned ADDR_W      = $clog2(CELLS);
  localparam int unsigned CNT_W       = $clog2(2 * CELLS + 1);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned POS_W       = 2;
  localparam int unsigned IN_TDATA_W  = ((DATA_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_W = DATA_W + 2 * POS_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Marks one operand pair on its way through the multiply-accumulate unit.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mac_tag_t;

  // Row-major address of a matrix cell.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(row) * ADDR_W'(DIM);
    return base + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

@@ src/mm3_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for both operand matrices. No dependencies.
`default_nettype none

module mm3_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 9
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/mm3_mac.sv @@
// Multiply-accumulate unit: registered 32x32 product, then a wrapping sum over
// the DIM operand pairs of one product element. Depends on mm3_pkg.
`default_nettype none

module mm3_mac (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mm3_pkg::mac_tag_t             tag_i,
  input  wire logic [mm3_pkg::DATA_W-1:0]    left_i,
  input  wire logic [mm3_pkg::DATA_W-1:0]    right_i,
  output      logic                          busy_o,
  output      logic                          res_valid_o,
  output      logic [mm3_pkg::DATA_W-1:0]    res_value_o,
  output      logic [mm3_pkg::IDX_W-1:0]     res_row_o,
  output      logic [mm3_pkg::IDX_W-1:0]     res_col_o
);

  mm3_pkg::mac_tag_t            ptag_q;
  logic [mm3_pkg::DATA_W-1:0]   prod_q;
  logic [mm3_pkg::DATA_W-1:0]   acc_q;
  logic [mm3_pkg::DATA_W-1:0]   sum;
  logic [mm3_pkg::DATA_W-1:0]   full_prod;

  // The low word of the product is the same for signed and unsigned operands.
  assign full_prod = left_i * right_i;

  // Tag travels with the product register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptag_q <= '0;
    end else begin
      ptag_q <= tag_i;
    end
  end

  // Accumulation restarts on the first pair of each element.
  assign sum = (ptag_q.first ? '0 : acc_q) + prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= full_prod;
    if (ptag_q.valid) begin
      acc_q <= sum;
    end
  end

  assign busy_o      = ptag_q.valid;
  assign res_valid_o = ptag_q.valid && ptag_q.last;
  assign res_value_o = sum;
  assign res_row_o   = ptag_q.row;
  assign res_col_o   = ptag_q.col;

endmodule

`default_nettype wire

@@ src/matrix_multiply_3x3.sv @@
// Streaming 3x3 integer matrix multiplier: load 18 words, emit 9 product words.
// Depends on mm3_pkg, mm3_ram and mm3_mac.
// Throughput: one input word per cycle while loading; then, for each product word, 3 reads
// are issued and the multiply-accumulate pipeline drains before the next word starts.
// Reset clears the load count, sequencer and valid flags; the RAMs are not cleared.
`default_nettype none

module matrix_multiply_3x3 (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output      logic                              s_axis_tready_o,
  // [31:0] element_value
  input  wire logic [mm3_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output      logic                              m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // [31:0] product_value, [33:32] row_index, [35:34] col_index, rest zero
  output      logic [mm3_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // last_element
  output      logic                              m_axis_tlast_o
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  localparam logic [mm3_pkg::CNT_W-1:0] CNT_CELLS = mm3_pkg::CNT_W'(mm3_pkg::CELLS);
  localparam logic [mm3_pkg::CNT_W-1:0] CNT_LAST  = mm3_pkg::CNT_W'(2 * mm3_pkg::CELLS - 1);
  localparam logic [mm3_pkg::IDX_W-1:0] IDX_LAST  = mm3_pkg::IDX_W'(mm3_pkg::DIM - 1);

  logic [1:0]                   state_q, state_d;
  logic [mm3_pkg::CNT_W-1:0]    load_cnt_q, load_cnt_d;
  logic [mm3_pkg::IDX_W-1:0]    row_q, row_d, col_q, col_d, k_q, k_d;
  logic                         done_q, done_d;
  mm3_pkg::mac_tag_t            tag_q, tag_d;

  logic                         in_accept, out_accept;
  logic                         left_we, right_we;
  logic [mm3_pkg::ADDR_W-1:0]   left_waddr, right_waddr, left_raddr, right_raddr;
  logic [mm3_pkg::DATA_W-1:0]   in_value, left_rdata, right_rdata;

  logic                         mac_busy, res_valid;
  logic [mm3_pkg::DATA_W-1:0]   res_value;
  logic [mm3_pkg::IDX_W-1:0]    res_row, res_col;

  logic                         out_valid_q, out_valid_d;
  logic [mm3_pkg::DATA_W-1:0]   out_value_q;
  logic [mm3_pkg::POS_W-1:0]    out_row_q, out_col_q;
  logic                         out_last_q;

  assign in_accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_accept = m_axis_tvalid_o && m_axis_tready_i;
  assign in_value   = s_axis_tdata_i[mm3_pkg::DATA_W-1:0];

  // Load words go to the left matrix first, then to the right one.
  assign left_we     = in_accept && (load_cnt_q < CNT_CELLS);
  assign right_we    = in_accept && (load_cnt_q >= CNT_CELLS);
  assign left_waddr  = load_cnt_q[mm3_pkg::ADDR_W-1:0];
  assign right_waddr = mm3_pkg::ADDR_W'(load_cnt_q - CNT_CELLS);
  assign left_raddr  = mm3_pkg::cell_addr(row_q, k_q);
  assign right_raddr = mm3_pkg::cell_addr(k_q, col_q);

  mm3_ram #(
    .WIDTH (mm3_pkg::DATA_W),
    .DEPTH (mm3_pkg::CELLS)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (left_we),
    .waddr_i (left_waddr),
    .wdata_i (in_value),
    .raddr_i (left_raddr),
    .rdata_o (left_rdata)
  );

  mm3_ram #(
    .WIDTH (mm3_pkg::DATA_W),
    .DEPTH (mm3_pkg::CELLS)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (right_we),
    .waddr_i (right_waddr),
    .wdata_i (in_value),
    .raddr_i (right_raddr),
    .rdata_o (right_rdata)
  );

  mm3_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag_q),
    .left_i      (left_rdata),
    .right_i     (right_rdata),
    .busy_o      (mac_busy),
    .res_valid_o (res_valid),
    .res_value_o (res_value),
    .res_row_o   (res_row),
    .res_col_o   (res_col)
  );

  // Sequencer: load, then issue DIM reads per product word and wait for it.
  // A full load also passes through the wait state, so that a new run only
  // starts once the last word of the previous run has left the output register.
  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    row_d      = row_q;
    col_d      = col_q;
    k_d        = k_q;
    done_d     = done_q;
    tag_d      = '0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_accept) begin
          if (load_cnt_q == CNT_LAST) begin
            load_cnt_d = '0;
            row_d      = '0;
            col_d      = '0;
            k_d        = '0;
            state_d    = ST_WAIT;
          end else begin
            load_cnt_d = load_cnt_q + 1'b1;
          end
        end
      end
      ST_ISSUE: begin
        tag_d.valid = 1'b1;
        tag_d.first = (k_q == '0);
        tag_d.last  = (k_q == IDX_LAST);
        tag_d.row   = row_q;
        tag_d.col   = col_q;
        if (k_q == IDX_LAST) begin
          k_d     = '0;
          state_d = ST_WAIT;
          if (col_q == IDX_LAST) begin
            col_d = '0;
            if (row_q == IDX_LAST) begin
              row_d  = '0;
              done_d = 1'b1;
            end else begin
              row_d = row_q + 1'b1;
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (!tag_q.valid && !mac_busy) begin
          if (done_q) begin
            done_d  = 1'b0;
            state_d = ST_LOAD;
          end else if (!out_valid_q || m_axis_tready_i) begin
            state_d = ST_ISSUE;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
      k_q        <= '0;
      done_q     <= 1'b0;
      tag_q      <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      row_q      <= row_d;
      col_q      <= col_d;
      k_q        <= k_d;
      done_q     <= done_d;
      tag_q      <= tag_d;
    end
  end

  // Output register; a new word only arrives once the previous one has left.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_accept) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_value_q <= res_value;
      out_row_q   <= mm3_pkg::POS_W'(res_row);
      out_col_q   <= mm3_pkg::POS_W'(res_col);
      out_last_q  <= (res_row == IDX_LAST) && (res_col == IDX_LAST);
    end
  end

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = mm3_pkg::OUT_TDATA_W'({out_col_q, out_row_q, out_value_q});
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  // A finished product word never lands on an output word still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_q || m_axis_tready_i))
    else $error("product word overwrote a pending output word");

  // The load count stays inside one run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_cnt_q <= CNT_LAST)
    else $error("load count out of range");

  // Loading always resumes at the start of a new left matrix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready_o) |-> (load_cnt_q == '0))
    else $error("loading resumed with a nonzero count");

  // The flagged last word is the bottom-right product element.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      (out_row_q == mm3_pkg::POS_W'(IDX_LAST) && out_col_q == mm3_pkg::POS_W'(IDX_LAST)))
    else $error("last flag on a word that is not the final element");
`endif

endmodule

`default_nettype wire
